// ===== hdl/mlld_pkg.sv =====
// ----------------------------------------------------------------------------
// mlld_pkg
// Shared types, register codes and the Morse letter table for the
// light letter decoder.
// ----------------------------------------------------------------------------
package mlld_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_DIT_TICKS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_UNITS       = 2'd2;

   localparam logic [23:0] DIT_TICKS_RST       = 24'd125000;
   localparam logic [15:0] LEVEL_THRESHOLD_RST = 16'd256;
   localparam logic [2:0]  GAP_UNITS_RST       = 3'd3;

   // frame phase codes
   localparam logic [1:0] PH_SEEK   = 2'd0;
   localparam logic [1:0] PH_SYNC   = 2'd1;
   localparam logic [1:0] PH_RECORD = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   typedef struct packed {
      logic [1:0] phase;
      logic [2:0] dark_run;
      logic [4:0] letter;
      logic       error;
   } pt_ctl_type;

   localparam pt_ctl_type CTL_CLEAR = '{phase: PH_SEEK, dark_run: 3'd0,
                                        letter: 5'd0, error: 1'b0};

   typedef struct packed {
      logic [12:0] bits;
      logic [3:0]  len;
   } code_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } match_type;

   // element count and dash mask per letter, bit e set = element e is a dah
   localparam logic [2:0] MORSE_COUNT [0:25] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4};
   localparam logic [3:0] MORSE_DASH [0:25] = '{
      4'b0010, 4'b0001, 4'b0101, 4'b0001, 4'b0000, 4'b0100, 4'b0011,
      4'b0000, 4'b0000, 4'b1110, 4'b0101, 4'b0010, 4'b0011, 4'b0001,
      4'b0111, 4'b0110, 4'b1011, 4'b0010, 4'b0000, 4'b0001, 4'b0100,
      4'b1000, 4'b0110, 4'b1001, 4'b1101, 4'b0011};

   // on/off pattern of one letter: dit "1", dah "111", element gap "0"
   function automatic code_type morse_code(input int unsigned k);
      code_type c;
      c.bits = '0;
      c.len  = '0;
      for (int e = 0; e < 4; e++) begin
         if (e < int'(MORSE_COUNT[k])) begin
            if (e != 0) begin
               c.bits = {c.bits[11:0], 1'b0};
               c.len  = c.len + 4'd1;
            end
            if (MORSE_DASH[k][e]) begin
               c.bits = {c.bits[9:0], 3'b111};
               c.len  = c.len + 4'd3;
            end else begin
               c.bits = {c.bits[11:0], 1'b1};
               c.len  = c.len + 4'd1;
            end
         end
      end
      return c;
   endfunction

   function automatic match_type morse_match(input logic [31:0] bits,
                                             input logic [5:0]  len);
      match_type m;
      code_type  c;
      m.hit = 1'b0;
      m.idx = '0;
      for (int k = 0; k < 26; k++) begin
         c = morse_code(k);
         if (!m.hit && len == 6'(c.len) && bits == 32'(c.bits)) begin
            m.hit = 1'b1;
            m.idx = 5'(k);
         end
      end
      return m;
   endfunction

endpackage

// ===== hdl/mlld_ifs.sv =====
// ----------------------------------------------------------------------------
// mlld channel interfaces
// Sample, letter and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlld_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_level;
   logic [31:0] sample_time;
   logic        frame_last;

   modport source (output valid, sample_level, sample_time, frame_last, input ready);
   modport sink   (input valid, sample_level, sample_time, frame_last, output ready);
endinterface

interface mlld_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] letter_index;
   logic       decode_error;

   modport source (output valid, letter_index, decode_error, input ready);
   modport sink   (input valid, letter_index, decode_error, output ready);
endinterface

interface mlld_csr_if;
   import mlld_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/morse_light_letter_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// morse_light_letter_decoder_unit
// Decodes one Morse letter per frame of time-stamped light samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     beat payload
//  req_chan  in         valid/ready   sample_level, sample_time, frame_last
//  rsp_chan  out        valid/ready   letter_index, decode_error
//  csr_chan  in         valid/ready   index, data (always ready)
//
//  One sample beat per clock. A sample can resolve up to two sample points
//  (the held previous sample, then the current one); both are evaluated by
//  two chained point units between the frame state and the result register.
//  The letter beat appears the cycle after the frame_last beat.
//  Synchronous reset clears the frame state and loads register defaults.
//  req_chan is held off only while a letter waits and rsp_chan is stalled.
// ----------------------------------------------------------------------------
module morse_light_letter_decoder_unit #(
   parameter int unsigned MAX_SYMBOL_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mlld_req_if.sink   req_chan,
   mlld_rsp_if.source rsp_chan,
   mlld_csr_if.sink   csr_chan
);
   import mlld_pkg::*;

   localparam int unsigned LEN_W = $clog2(MAX_SYMBOL_BITS + 1);

   // configuration
   logic [23:0] dit_ticks_ff, dit_ticks_in;
   logic [15:0] thresh_ff, thresh_in;
   logic [2:0]  gap_ff, gap_in;

   // frame state
   pt_ctl_type                 ctl_ff, ctl_in;
   logic [MAX_SYMBOL_BITS-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [33:0]                target_ff, target_in;
   logic                       have_prev_ff, have_prev_in;
   logic                       prev_used_ff, prev_used_in;
   logic [15:0]                prev_level_ff, prev_level_in;
   logic [31:0]                prev_time_ff, prev_time_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_letter_ff, rsp_letter_in;
   logic       rsp_error_ff, rsp_error_in;

   // datapath
   logic                       accept;
   logic [15:0]                lvl;
   logic [33:0]                now2, prev2, dit1, dit2;
   logic [33:0]                dist_cur, dist_prev, cur_target, prev_target;
   logic                       active, crossing, due, pick_cur, second_due, now_used;
   logic [15:0]                first_level;
   pt_ctl_type                 pt0_ctl, pt1_ctl, step_ctl;
   logic [MAX_SYMBOL_BITS-1:0] pt0_bits, pt1_bits, step_bits;
   logic [LEN_W-1:0]           pt0_len, pt1_len, step_len;
   logic [33:0]                step_target;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.letter_index = rsp_letter_ff;
   assign rsp_chan.decode_error = rsp_error_ff;

   mlld_point #(.MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)) u_point_first (
      .cur_ctl         (ctl_ff),
      .cur_bits        (bits_ff),
      .cur_len         (len_ff),
      .level           (first_level),
      .level_threshold (thresh_ff),
      .gap_units       (gap_ff),
      .nxt_ctl         (pt0_ctl),
      .nxt_bits        (pt0_bits),
      .nxt_len         (pt0_len)
   );

   mlld_point #(.MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)) u_point_second (
      .cur_ctl         (pt0_ctl),
      .cur_bits        (pt0_bits),
      .cur_len         (pt0_len),
      .level           (lvl),
      .level_threshold (thresh_ff),
      .gap_units       (gap_ff),
      .nxt_ctl         (pt1_ctl),
      .nxt_bits        (pt1_bits),
      .nxt_len         (pt1_len)
   );

   // sample point selection, times kept in half ticks
   always_comb begin
      lvl         = req_chan.sample_level;
      now2        = {1'b0, req_chan.sample_time, 1'b0};
      prev2       = {1'b0, prev_time_ff, 1'b0};
      dit1        = {10'd0, dit_ticks_ff};
      dit2        = {9'd0, dit_ticks_ff, 1'b0};
      active      = (ctl_ff.phase == PH_SYNC) || (ctl_ff.phase == PH_RECORD);
      crossing    = have_prev_ff &&
                    ((lvl > thresh_ff && prev_level_ff < thresh_ff) ||
                     (lvl < thresh_ff && prev_level_ff > thresh_ff));
      due         = active && (now2 > target_ff);
      dist_cur    = now2 - target_ff;
      dist_prev   = (prev2 > target_ff) ? (prev2 - target_ff) : (target_ff - prev2);
      // ties go to the earlier sample; a sample is never used twice
      pick_cur    = prev_used_ff || !have_prev_ff || (dist_cur < dist_prev);
      first_level = pick_cur ? lvl : prev_level_ff;
      cur_target  = now2 + dit2;
      prev_target = prev2 + dit2;
      second_due  = !pick_cur && (now2 > prev_target) &&
                    ((pt0_ctl.phase == PH_SYNC) || (pt0_ctl.phase == PH_RECORD));

      step_ctl    = ctl_ff;
      step_bits   = bits_ff;
      step_len    = len_ff;
      step_target = target_ff;
      now_used    = 1'b0;

      if (ctl_ff.phase == PH_SEEK) begin
         if (crossing) begin
            step_ctl.phase    = PH_SYNC;
            step_ctl.dark_run = 3'd0;
            step_target       = now2 + dit1;
         end
      end else if (due) begin
         if (second_due) begin
            step_ctl    = pt1_ctl;
            step_bits   = pt1_bits;
            step_len    = pt1_len;
            step_target = cur_target;
            now_used    = 1'b1;
         end else begin
            step_ctl    = pt0_ctl;
            step_bits   = pt0_bits;
            step_len    = pt0_len;
            step_target = pick_cur ? cur_target : prev_target;
            now_used    = pick_cur;
         end
      end
   end

   // next state
   always_comb begin
      dit_ticks_in  = dit_ticks_ff;
      thresh_in     = thresh_ff;
      gap_in        = gap_ff;
      ctl_in        = ctl_ff;
      bits_in       = bits_ff;
      len_in        = len_ff;
      target_in     = target_ff;
      have_prev_in  = have_prev_ff;
      prev_used_in  = prev_used_ff;
      prev_level_in = prev_level_ff;
      prev_time_in  = prev_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_letter_in = rsp_letter_ff;
      rsp_error_in  = rsp_error_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_DIT_TICKS:       dit_ticks_in = csr_chan.data[23:0];
            CSR_LEVEL_THRESHOLD: thresh_in    = csr_chan.data[15:0];
            CSR_GAP_UNITS:       gap_in       = csr_chan.data[2:0];
            default: begin
            end
         endcase
      end

      if (accept) begin
         if (req_chan.frame_last) begin
            rsp_valid_in = 1'b1;
            if (step_ctl.phase == PH_DONE) begin
               rsp_letter_in = step_ctl.letter;
               rsp_error_in  = step_ctl.error;
            end else begin
               rsp_letter_in = 5'd0;
               rsp_error_in  = 1'b1;
            end
            ctl_in        = CTL_CLEAR;
            bits_in       = '0;
            len_in        = '0;
            target_in     = '0;
            have_prev_in  = 1'b0;
            prev_used_in  = 1'b0;
            prev_level_in = '0;
            prev_time_in  = '0;
         end else begin
            ctl_in        = step_ctl;
            bits_in       = step_bits;
            len_in        = step_len;
            target_in     = step_target;
            have_prev_in  = 1'b1;
            prev_used_in  = now_used;
            prev_level_in = lvl;
            prev_time_in  = req_chan.sample_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ticks_ff  <= DIT_TICKS_RST;
         thresh_ff     <= LEVEL_THRESHOLD_RST;
         gap_ff        <= GAP_UNITS_RST;
         ctl_ff        <= CTL_CLEAR;
         bits_ff       <= '0;
         len_ff        <= '0;
         target_ff     <= '0;
         have_prev_ff  <= 1'b0;
         prev_used_ff  <= 1'b0;
         prev_level_ff <= '0;
         prev_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dit_ticks_ff  <= dit_ticks_in;
         thresh_ff     <= thresh_in;
         gap_ff        <= gap_in;
         ctl_ff        <= ctl_in;
         bits_ff       <= bits_in;
         len_ff        <= len_in;
         target_ff     <= target_in;
         have_prev_ff  <= have_prev_in;
         prev_used_ff  <= prev_used_in;
         prev_level_ff <= prev_level_in;
         prev_time_ff  <= prev_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_letter_ff <= rsp_letter_in;
      rsp_error_ff  <= rsp_error_in;
   end

   // checks
   a_last_gives_letter: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.frame_last |=> rsp_chan.valid)
      else $error("frame_last beat did not produce a letter beat");

   a_error_letter_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.decode_error |-> rsp_chan.letter_index == 5'd0)
      else $error("error beat carries a nonzero letter");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.letter_index <= 5'd25)
      else $error("letter index out of range");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("sample accepted while a letter is stalled");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_SYMBOL_BITS))
      else $error("symbol length exceeds bit store");

endmodule

// ===== hdl/mlld_point.sv =====
// ----------------------------------------------------------------------------
// mlld_point
// Evaluates one sample point: gap wait, bit recording, letter match.
// ----------------------------------------------------------------------------
module mlld_point #(
   parameter int unsigned MAX_SYMBOL_BITS = 16,
   localparam int unsigned LEN_W = $clog2(MAX_SYMBOL_BITS + 1)
) (
   input  mlld_pkg::pt_ctl_type        cur_ctl,
   input  logic [MAX_SYMBOL_BITS-1:0]  cur_bits,
   input  logic [LEN_W-1:0]            cur_len,
   input  logic [15:0]                 level,
   input  logic [15:0]                 level_threshold,
   input  logic [2:0]                  gap_units,
   output mlld_pkg::pt_ctl_type        nxt_ctl,
   output logic [MAX_SYMBOL_BITS-1:0]  nxt_bits,
   output logic [LEN_W-1:0]            nxt_len
);
   import mlld_pkg::*;

   localparam int unsigned SUM_W = LEN_W + 1;

   logic [2:0]       eff_gap;
   logic [3:0]       run_inc;
   logic             gap_hit;
   logic [SUM_W-1:0] new_len;
   logic [3:0]       shift;
   match_type        hit;

   always_comb begin
      eff_gap = (gap_units == 3'd0) ? 3'd1 : gap_units;
      run_inc = {1'b0, cur_ctl.dark_run} + 4'd1;
      gap_hit = run_inc >= {1'b0, eff_gap};
      new_len = SUM_W'(cur_len) + SUM_W'(cur_ctl.dark_run) + SUM_W'(1);
      shift   = run_inc;
      hit     = morse_match(32'(cur_bits), 6'(cur_len));

      nxt_ctl  = cur_ctl;
      nxt_bits = cur_bits;
      nxt_len  = cur_len;

      case (cur_ctl.phase)
         PH_SYNC: begin
            if (level < level_threshold) begin
               if (gap_hit) begin
                  nxt_ctl.phase    = PH_RECORD;
                  nxt_ctl.dark_run = 3'd0;
                  nxt_bits         = '0;
                  nxt_len          = '0;
               end else begin
                  nxt_ctl.dark_run = run_inc[2:0];
               end
            end else begin
               nxt_ctl.dark_run = 3'd0;
            end
         end
         PH_RECORD: begin
            if (level > level_threshold) begin
               if (new_len > SUM_W'(MAX_SYMBOL_BITS)) begin
                  nxt_ctl.phase  = PH_DONE;
                  nxt_ctl.letter = 5'd0;
                  nxt_ctl.error  = 1'b1;
               end else begin
                  // pending dark bits go in ahead of the new on bit
                  nxt_bits         = (cur_bits << shift) | MAX_SYMBOL_BITS'(1);
                  nxt_len          = new_len[LEN_W-1:0];
                  nxt_ctl.dark_run = 3'd0;
               end
            end else if (gap_hit) begin
               nxt_ctl.phase = PH_DONE;
               if (cur_len != '0 && hit.hit) begin
                  nxt_ctl.letter = hit.idx;
                  nxt_ctl.error  = 1'b0;
               end else begin
                  nxt_ctl.letter = 5'd0;
                  nxt_ctl.error  = 1'b1;
               end
            end else begin
               nxt_ctl.dark_run = run_inc[2:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== tb/tb_morse_light_letter_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_morse_light_letter_decoder_unit
// Self-checking bench for the Morse light letter decoder. Sample frames are
// built from on/off unit patterns of real letters, broken symbols, cut and
// noisy frames; a cycle-free model of the decoder predicts each letter beat,
// which the result monitor checks field by field when the beat is taken.
// ----------------------------------------------------------------------------
module tb_morse_light_letter_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mlld_pkg::*;

   localparam int unsigned SYMBOL_BITS_MAX = 16;
   localparam int unsigned IDLE_LIMIT      = 4000;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned RANDOM_SAMPLES  = 1600;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      bit [4:0] letter;
      bit       err;
   } letter_beat_type;

   typedef bit unit_seq_type [$];

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_type;

   logic clock;
   logic reset;

   mlld_req_if req_bus ();
   mlld_rsp_if rsp_bus ();
   mlld_csr_if csr_bus ();

   morse_light_letter_decoder_unit #(
      .MAX_SYMBOL_BITS(SYMBOL_BITS_MAX)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // register copies
   bit [23:0] cfg_dit;
   bit [15:0] cfg_thr;
   bit [2:0]  cfg_gap;

   // frame tracker state
   bit [1:0]    trk_phase;
   bit          trk_have_prev;
   bit [15:0]   trk_prev_level;
   bit [31:0]   trk_prev_time;
   bit          trk_prev_used;
   bit [35:0]   trk_target;     // half ticks
   int unsigned trk_dark;
   bit [31:0]   trk_bits;
   int unsigned trk_len;
   bit [4:0]    trk_letter;
   bit          trk_err;

   letter_beat_type letters_due [$];

   int unsigned fail_count;
   int unsigned samples_sent;
   int unsigned letters_sent;
   int unsigned burst_left;
   int unsigned idle_cycles;
   bit          hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // letter model
   // ------------------------------------------------------------------
   function automatic string letter_text(input int unsigned k);
      case (k)
         0: return ".-";    1: return "-...";  2: return "-.-.";  3: return "-..";
         4: return ".";     5: return "..-.";  6: return "--.";   7: return "....";
         8: return "..";    9: return ".---"; 10: return "-.-";  11: return ".-..";
        12: return "--";   13: return "-.";   14: return "---";  15: return ".--.";
        16: return "--.-"; 17: return ".-.";  18: return "...";  19: return "-";
        20: return "..-";  21: return "...-"; 22: return ".--";  23: return "-..-";
        24: return "-.--"; default: return "--..";
      endcase
   endfunction

   // on/off pattern: dit 1, dah 111, element gap 0
   function automatic void letter_code(input int unsigned k, output bit [31:0] bits,
                                       output int unsigned len);
      string s;
      s    = letter_text(k);
      bits = '0;
      len  = 0;
      for (int e = 0; e < s.len(); e++) begin
         if (e != 0) begin
            bits = bits << 1;
            len  = len + 1;
         end
         if (s[e] == ".") begin
            bits = (bits << 1) | 32'd1;
            len  = len + 1;
         end else begin
            bits = (bits << 3) | 32'd7;
            len  = len + 3;
         end
      end
   endfunction

   function automatic int unsigned gap_points();
      return (cfg_gap == 3'd0) ? 1 : int'(cfg_gap);
   endfunction

   function automatic void clear_frame_state();
      trk_phase      = PH_SEEK;
      trk_have_prev  = 1'b0;
      trk_prev_level = '0;
      trk_prev_time  = '0;
      trk_prev_used  = 1'b0;
      trk_target     = '0;
      trk_dark       = 0;
      trk_bits       = '0;
      trk_len        = 0;
      trk_letter     = '0;
      trk_err        = 1'b0;
   endfunction

   function automatic void fail_letter();
      trk_letter = '0;
      trk_err    = 1'b1;
      trk_phase  = PH_DONE;
   endfunction

   function automatic void close_symbol();
      bit [31:0]   bits;
      int unsigned len;
      if (trk_len == 0) begin
         fail_letter();
         return;
      end
      for (int k = 0; k < 26; k++) begin
         letter_code(k, bits, len);
         if (len == trk_len && bits == trk_bits) begin
            trk_letter = 5'(k);
            trk_err    = 1'b0;
            trk_phase  = PH_DONE;
            return;
         end
      end
      fail_letter();
   endfunction

   function automatic void take_point(input bit [15:0] level);
      if (trk_phase == PH_SYNC) begin
         if (level < cfg_thr) begin
            trk_dark++;
            if (trk_dark >= gap_points()) begin
               trk_phase = PH_RECORD;
               trk_dark  = 0;
               trk_bits  = '0;
               trk_len   = 0;
            end
         end else begin
            trk_dark = 0;
         end
      end else if (trk_phase == PH_RECORD) begin
         if (level > cfg_thr) begin
            if (trk_len + trk_dark + 1 > SYMBOL_BITS_MAX) begin
               fail_letter();
               return;
            end
            trk_bits = ((trk_bits << trk_dark) << 1) | 32'd1;
            trk_len  = trk_len + trk_dark + 1;
            trk_dark = 0;
         end else begin
            trk_dark++;
            if (trk_dark >= gap_points())
               close_symbol();
         end
      end
   endfunction

   function automatic void decode_sample(input bit [15:0] level, input bit [31:0] stamp,
                                         input bit last);
      bit [35:0]       now2;
      bit [35:0]       prev2;
      bit [35:0]       dc;
      bit [35:0]       dp;
      bit              now_used;
      letter_beat_type beat;
      now2     = {3'b000, stamp, 1'b0};
      now_used = 1'b0;
      if (trk_phase == PH_SEEK) begin
         if (trk_have_prev && ((level > cfg_thr && trk_prev_level < cfg_thr) ||
                               (level < cfg_thr && trk_prev_level > cfg_thr))) begin
            trk_phase  = PH_SYNC;
            trk_dark   = 0;
            trk_target = now2 + 36'(cfg_dit);
         end
      end else begin
         // at most two points per sample: the held previous one, then this one
         while ((trk_phase == PH_SYNC || trk_phase == PH_RECORD) && now2 > trk_target) begin
            prev2 = {3'b000, trk_prev_time, 1'b0};
            dc    = now2 - trk_target;
            dp    = (prev2 > trk_target) ? prev2 - trk_target : trk_target - prev2;
            if (trk_prev_used || !trk_have_prev || dc < dp) begin
               take_point(level);
               trk_target = now2 + 36'({cfg_dit, 1'b0});
               now_used   = 1'b1;
            end else begin
               take_point(trk_prev_level);
               trk_target    = prev2 + 36'({cfg_dit, 1'b0});
               trk_prev_used = 1'b1;
            end
         end
      end
      trk_prev_level = level;
      trk_prev_time  = stamp;
      trk_prev_used  = now_used;
      trk_have_prev  = 1'b1;
      if (last) begin
         beat.letter = (trk_phase == PH_DONE) ? trk_letter : 5'd0;
         beat.err    = (trk_phase == PH_DONE) ? trk_err : 1'b1;
         letters_due = {letters_due, beat};
         clear_frame_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic bit [15:0] bright_level();
      if (cfg_thr == 16'hFFFF)
         return 16'hFFFF;
      return 16'($urandom_range(32'(cfg_thr) + 1, 65535));
   endfunction

   function automatic bit [15:0] dark_level();
      if (cfg_thr == 16'h0000)
         return 16'h0000;
      return 16'($urandom_range(0, 32'(cfg_thr) - 1));
   endfunction

   function automatic unit_seq_type letter_body(input int unsigned k);
      bit [31:0]    bits;
      int unsigned  len;
      unit_seq_type seq;
      letter_code(k, bits, len);
      for (int i = int'(len) - 1; i >= 0; i--)
         seq = {seq, bits[i]};
      return seq;
   endfunction

   // dark lead-in, sync mark, gap, symbol, gap, then a random tail
   function automatic unit_seq_type frame_around(input unit_seq_type body,
                                                 input int unsigned gap,
                                                 input int unsigned tail);
      unit_seq_type seq;
      seq = {seq, 1'b0};
      seq = {seq, 1'b1};
      repeat (gap) seq = {seq, 1'b0};
      foreach (body[i]) seq = {seq, body[i]};
      repeat (gap) seq = {seq, 1'b0};
      repeat (tail) seq = {seq, 1'($urandom_range(0, 1))};
      return seq;
   endfunction

   task automatic send_sample(input bit [15:0] level, input bit [31:0] stamp, input bit last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.sample_level <= level;
      req_bus.sample_time  <= stamp;
      req_bus.frame_last   <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decode_sample(level, stamp, last);
      samples_sent++;
   endtask

   // spu: samples per unit; frame_last goes on the final sample
   task automatic send_units(input unit_seq_type units, input int unsigned spu_lo,
                             input int unsigned spu_hi, input bit jitter, input bit noisy);
      longint unsigned d;
      longint unsigned span;
      longint unsigned t0;
      longint unsigned tt;
      int unsigned     k;
      bit [15:0]       lv [$];
      bit [31:0]       ts [$];
      d    = (cfg_dit == 0) ? 1 : longint'(cfg_dit);
      span = (units.size() + 1) * d;
      if ($urandom_range(0, 15) == 0 || span >= 64'hFFFF_FFFF)
         t0 = $urandom;
      else
         t0 = $urandom_range(0, 32'(64'hFFFF_FFFF - span));
      foreach (units[u]) begin
         k = $urandom_range(spu_lo, spu_hi);
         for (int j = 0; j < k; j++) begin
            tt = t0 + longint'(u) * d + (longint'(j) * d) / k;
            if (jitter)
               tt = tt + $urandom_range(0, 32'(d / 8));
            lv = {lv, (units[u] ? bright_level() : dark_level())};
            ts = {ts, 32'(tt)};
            if (noisy && $urandom_range(0, 11) == 0) begin
               case ($urandom_range(0, 2))
                  0: lv[$] = 16'($urandom);
                  1: lv[$] = cfg_thr;
                  default: ts[$] = $urandom;
               endcase
            end
         end
      end
      foreach (lv[i])
         send_sample(lv[i], ts[i], i == lv.size() - 1);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_DIT_TICKS:       cfg_dit = value;
         CSR_LEVEL_THRESHOLD: cfg_thr = value[15:0];
         CSR_GAP_UNITS:       cfg_gap = value[2:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [23:0] dit, input logic [15:0] thr,
                                input logic [2:0] gap, input bit poke_unused);
      if (poke_unused)
         write_register(CSR_UNUSED, 24'($urandom));
      write_register(CSR_DIT_TICKS, dit);
      write_register(CSR_LEVEL_THRESHOLD, 24'(thr));
      write_register(CSR_GAP_UNITS, 24'(gap));
      csr_bus.valid <= 1'b0;
   endtask

   // drop valid, let every letter come out, then let the pipe settle
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (letters_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result monitor and receiver stalls
   // ------------------------------------------------------------------
   task automatic check_letter_beat();
      letter_beat_type want;
      if (letters_due.size() == 0) begin
         $error("letter beat with none pending: letter_index %0d decode_error %0b",
                rsp_bus.letter_index, rsp_bus.decode_error);
         fail_count++;
         return;
      end
      want = letters_due.pop_front();
      if (rsp_bus.letter_index !== want.letter) begin
         $error("letter_index: expected %0d, actual %0d", want.letter, rsp_bus.letter_index);
         fail_count++;
      end
      if (rsp_bus.decode_error !== want.err) begin
         $error("decode_error: expected %0b, actual %0b", want.err, rsp_bus.decode_error);
         fail_count++;
      end
   endtask

   initial begin
      rx_pattern_type rx_mode;
      int unsigned    rx_left;
      int unsigned    hold_left;
      bit             take;
      rx_mode   = RX_OPEN;
      rx_left   = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_letter_beat();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (rx_left == 0) begin
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:   take = 1'b1;
            RX_COIN:   take = 1'($urandom_range(0, 1));
            RX_SPARSE: take = ($urandom_range(0, 3) == 0);
            default:   take = ($urandom_range(0, 9) != 0);
         endcase
         if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
         end
         rsp_bus.ready <= take;
      end
   end

   // watchdog: cycles without any beat on any channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // letter E at reset settings, one sample per unit on exact unit starts,
   // so the first sample point lands on a tie and the earlier sample wins
   task automatic test_default_registers();
      send_units(frame_around(letter_body(4), gap_points(), 1), 1, 1, 1'b0, 1'b0);
   endtask

   task automatic test_edge_cases();
      unit_seq_type units;
      // frame of a single sample
      send_sample(dark_level(), 32'd1000, 1'b1);
      // levels equal to the threshold never cross
      send_sample(cfg_thr, 32'd1000, 1'b0);
      send_sample(bright_level(), 32'd2000, 1'b0);
      send_sample(cfg_thr, 32'd3000, 1'b1);
      // frame ends before the letter does
      units = frame_around(letter_body(0), 0, 0);
      send_units(units[0:2], 1, 1, 1'b0, 1'b0);
      // timestamps going backwards after the crossing
      send_sample(dark_level(), 32'd400000, 1'b0);
      send_sample(bright_level(), 32'd500000, 1'b0);
      send_sample(bright_level(), 32'd300000, 1'b0);
      send_sample(dark_level(), 32'd200000, 1'b1);
   endtask

   task automatic test_register_extremes();
      settle_block();
      set_registers(24'd2, 16'h0000, 3'd0, 1'b1);
      send_sample(16'h0000, 32'd10, 1'b0);
      send_sample(16'hFFFF, 32'd11, 1'b1);
      settle_block();
      set_registers(24'hFF_FFFF, 16'hFFFF, 3'd7, 1'b0);
      send_sample(16'h0000, 32'hFFFF_FFF0, 1'b0);
      send_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   // a letter waits behind a stalled receiver until the input stalls too
   task automatic test_backpressure();
      settle_block();
      set_registers(24'd16, 16'd128, 3'd2, 1'b0);
      hold_request = 1'b1;
      repeat (10) begin
         send_sample(dark_level(), 32'd100, 1'b0);
         send_sample(bright_level(), 32'd110, 1'b0);
         send_sample(dark_level(), 32'd120, 1'b1);
      end
      repeat (3)
         send_units(frame_around(letter_body($urandom_range(0, 25)), gap_points(), 1),
                    3, 3, 1'b1, 1'b0);
   endtask

   task automatic send_random_frame();
      int unsigned  kind;
      int unsigned  k;
      int unsigned  spu;
      int unsigned  n;
      int unsigned  g;
      bit [31:0]    stamp;
      unit_seq_type body;
      unit_seq_type units;
      kind = $urandom_range(0, 99);
      spu  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
      k    = (letters_sent < 26) ? letters_sent : $urandom_range(0, 25);
      g    = gap_points();
      if (kind < 70) begin
         letters_sent++;
         send_units(frame_around(letter_body(k), g, $urandom_range(1, 3)), spu, spu, 1'b1,
                    1'b0);
      end else if (kind < 78) begin
         // arbitrary symbol, often past the bit store
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
         body = {body, 1'b1};
         repeat (n - 1) body = {body, 1'($urandom_range(0, 1))};
         send_units(frame_around(body, g, 1), spu, spu, 1'b1, 1'b0);
      end else if (kind < 86) begin
         send_units(frame_around(letter_body(k), g, 1), 1, 4, 1'b1, 1'b1);
      end else if (kind < 92) begin
         units = frame_around(letter_body(k), g, 1);
         n     = $urandom_range(0, units.size() - 2);
         send_units(units[0:n], spu, spu, 1'b1, 1'b0);
      end else if (kind < 97) begin
         n     = $urandom_range(1, 12);
         stamp = $urandom;
         for (int i = 0; i < n; i++) begin
            send_sample(16'($urandom), stamp, i == n - 1);
            stamp = ($urandom_range(0, 7) == 0) ? $urandom
                                                 : stamp + $urandom_range(0, 2 * cfg_dit + 2);
         end
      end else begin
         g = (g > 1 && $urandom_range(0, 1) == 1) ? g - 1 : g + 1;
         send_units(frame_around(letter_body(k), g, 1), spu, spu, 1'b1, 1'b0);
      end
   endtask

   task automatic test_random_letters();
      int unsigned stop_at;
      logic [23:0] dit;
      logic [15:0] thr;
      logic [2:0]  gap;
      stop_at = samples_sent + RANDOM_SAMPLES;
      while (samples_sent < stop_at) begin
         settle_block();
         case ($urandom_range(0, 9))
            0:       dit = 24'($urandom_range(0, 8));
            1, 2, 3, 4, 5, 6:
                     dit = 24'($urandom_range(8, 3000));
            7, 8:    dit = 24'($urandom_range(3000, 300000));
            default: dit = ($urandom_range(0, 1) == 1) ? 24'hFF_FFFF : 24'($urandom);
         endcase
         case ($urandom_range(0, 15))
            0:       thr = 16'h0000;
            1:       thr = 16'hFFFF;
            default: thr = 16'($urandom_range(16, 60000));
         endcase
         case ($urandom_range(0, 9))
            0:       gap = 3'd0;
            1:       gap = 3'd7;
            2:       gap = 3'($urandom_range(4, 6));
            default: gap = 3'($urandom_range(1, 3));
         endcase
         set_registers(dit, thr, gap, $urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 10)) send_random_frame();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.sample_level <= '0;
      req_bus.sample_time  <= '0;
      req_bus.frame_last   <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      cfg_dit      = DIT_TICKS_RST;
      cfg_thr      = LEVEL_THRESHOLD_RST;
      cfg_gap      = GAP_UNITS_RST;
      fail_count   = 0;
      samples_sent = 0;
      letters_sent = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      clear_frame_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_edge_cases();
      test_register_extremes();
      test_backpressure();
      test_random_letters();

      settle_block();
      if (fail_count == 0 && letters_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== morse_light_letter_decoder_unit.f =====
hdl/mlld_pkg.sv
hdl/mlld_ifs.sv
hdl/mlld_point.sv
hdl/morse_light_letter_decoder_unit.sv
tb/tb_morse_light_letter_decoder_unit.sv
